// ----- src/bsfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfp_pkg
// Shared types, constants and color helpers for the bitmap scanout block.
// ----------------------------------------------------------------------------
package bsfp_pkg;

  localparam int VRAM_DEPTH  = 32768;
  localparam int VRAM_AW     = $clog2(VRAM_DEPTH);
  localparam int BYTE_W      = 8;
  localparam int COORD_W     = 8;
  localparam int NIB_W       = 4;
  localparam int PAL_DEPTH   = 16;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // Columns left of this one take the vertical scroll.
  localparam logic [COORD_W-1:0] SCROLL_LIMIT = 8'd192;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_VRAM = 2'd0,
    CMD_WR_PAL  = 2'd1,
    CMD_RENDER  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCROLL = 2'd0,
    CFG_FLIP_X = 2'd1,
    CFG_FLIP_Y = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  // 3-bit channel to 8 bits: v<<5 | v<<2 | v>>1
  function automatic logic [7:0] expand3(input logic [2:0] v);
    expand3 = {v, v, v[2:1]};
  endfunction

  // 2-bit channel to 8 bits by replication
  function automatic logic [7:0] expand2(input logic [1:0] v);
    expand2 = {v, v, v, v};
  endfunction

endpackage

// ----- src/bsfp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfp_ram
// Generic single-port synchronous RAM, registered read with read enable.
// ----------------------------------------------------------------------------
module bsfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/bitmap_scanout_scroll_flip_palette.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_scanout_scroll_flip_palette
// 4bpp bitmap scanout: 32 KiB video RAM, flip, column-limited vertical
// scroll, 16-entry 3-3-2 palette expanded to 24-bit RGB.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in_     | to block  | in_valid / in_stall  | cmd, mem_addr, write_data, x, y
//  out_    | from block| out_valid / out_stall| color_index, red, green, blue
//  cfg_    | to block  | cfg_we (no wait)     | cfg_index, cfg_data
//
//  One transaction per cycle while in_stall is low. A render transaction
//  passes the video RAM read port register, then the palette lookup /
//  output register, before it shows on out_.
//  rst_n (synchronous) empties the pipeline, clears the palette and the
//  config registers; video RAM contents are left as they are.
//  in_stall rises only while the read stage holds a result and the output
//  register is full and stalled; the RAM read data holds in that case
//  because no new read is issued.
//
module bitmap_scanout_scroll_flip_palette (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [bsfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsfp_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bsfp_pkg::CMD_W-1:0]       in_cmd,
  input  logic [bsfp_pkg::VRAM_AW-1:0]     in_mem_addr,
  input  logic [bsfp_pkg::BYTE_W-1:0]      in_write_data,
  input  logic [bsfp_pkg::COORD_W-1:0]     in_pixel_x,
  input  logic [bsfp_pkg::COORD_W-1:0]     in_pixel_y,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bsfp_pkg::NIB_W-1:0]       out_color_index,
  output logic [bsfp_pkg::BYTE_W-1:0]      out_red,
  output logic [bsfp_pkg::BYTE_W-1:0]      out_green,
  output logic [bsfp_pkg::BYTE_W-1:0]      out_blue
);

  import bsfp_pkg::*;

  // Config registers
  logic [COORD_W-1:0] scroll_r;
  logic               flip_x_r;
  logic               flip_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_r <= '0;
      flip_x_r <= 1'b0;
      flip_y_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCROLL: scroll_r <= cfg_data[COORD_W-1:0];
        CFG_FLIP_X: flip_x_r <= cfg_data[0];
        CFG_FLIP_Y: flip_y_r <= cfg_data[0];
        default: ;  // unused index ignored
      endcase
    end
  end

  // Handshake / pipeline control
  logic in_acc;
  logic advance;       // read stage may move into output register
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic s1_hi_r;       // odd column: high nibble
  cmd_t cmd;

  assign cmd      = cmd_t'(in_cmd);
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  // Address generation: flip, then scroll for columns left of the limit
  logic [COORD_W-1:0] ex;
  logic [COORD_W-1:0] ey_f;
  logic [COORD_W-1:0] ey;
  logic [VRAM_AW-1:0] pix_addr;
  logic [VRAM_AW-1:0] ram_addr;
  logic               ram_we;
  logic               ram_re;
  logic [BYTE_W-1:0]  ram_rdata;

  always_comb begin
    ex   = in_pixel_x ^ {COORD_W{flip_x_r}};
    ey_f = in_pixel_y ^ {COORD_W{flip_y_r}};
    ey   = (ex < SCROLL_LIMIT) ? COORD_W'(ey_f + scroll_r) : ey_f;
    // 128 bytes per row: row in the top bits, column pair in the low seven
    pix_addr = {ey, ex[COORD_W-1:1]};
    ram_addr = (cmd == CMD_RENDER) ? pix_addr : in_mem_addr;
    ram_we   = in_acc && (cmd == CMD_WR_VRAM);
    ram_re   = in_acc && (cmd == CMD_RENDER);
  end

  bsfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (VRAM_DEPTH)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_write_data),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = (cmd == CMD_RENDER);
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_hi_r <= ex[0];
    end
  end

  // Palette: 16 byte registers, cleared at reset. A palette write accepted
  // in the same cycle a render leaves the read stage lands after that lookup,
  // which matches transaction order.
  logic [BYTE_W-1:0] palette_r [PAL_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAL_DEPTH; i++) begin
        palette_r[i] <= '0;
      end
    end else if (in_acc && (cmd == CMD_WR_PAL)) begin
      palette_r[in_mem_addr[NIB_W-1:0]] <= in_write_data;
    end
  end

  // Lookup and output register
  logic [NIB_W-1:0]  nib;
  logic [BYTE_W-1:0] pal;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [NIB_W-1:0]  color_r;
  logic [BYTE_W-1:0] red_r;
  logic [BYTE_W-1:0] green_r;
  logic [BYTE_W-1:0] blue_r;

  assign nib = s1_hi_r ? ram_rdata[7:4] : ram_rdata[3:0];
  assign pal = palette_r[nib];

  always_comb begin
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      color_r <= nib;
      red_r   <= expand3(pal[2:0]);
      green_r <= expand3(pal[5:3]);
      blue_r  <= expand2(pal[7:6]);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = color_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;

endmodule

// ----- src/bsfp_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfp_chk
// Port-level checks for the bitmap scanout block, bound to the top level.
// ----------------------------------------------------------------------------
module bsfp_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [bsfp_pkg::CMD_W-1:0]      in_cmd,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [bsfp_pkg::NIB_W-1:0]      out_color_index,
  input logic [bsfp_pkg::BYTE_W-1:0]     out_red,
  input logic [bsfp_pkg::BYTE_W-1:0]     out_green,
  input logic [bsfp_pkg::BYTE_W-1:0]     out_blue
);

  import bsfp_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // Input backpressure only comes from a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without output backpressure");

  // An accepted render transaction shows out_valid once past the read stage and output register
  a_render_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_cmd == CMD_RENDER)) |-> ##2 out_valid)
    else $error("render transaction produced no output");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_color_index)
      && $stable(out_red) && $stable(out_green) && $stable(out_blue)))
    else $error("stalled result changed");

endmodule

bind bitmap_scanout_scroll_flip_palette bsfp_chk u_bsfp_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_cmd          (in_cmd),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_color_index (out_color_index),
  .out_red         (out_red),
  .out_green       (out_green),
  .out_blue        (out_blue)
);
